// ===== design/triangle_tangent_accumulator_assert.svh =====
// Assertion macros for the triangle tangent accumulator.
`ifndef TRIANGLE_TANGENT_ACCUMULATOR_ASSERT_SVH
`define TRIANGLE_TANGENT_ACCUMULATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define TTA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tta: assertion failed");
`define TTA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tta: assertion failed");
`else
`define TTA_ASSERT_IMP(lbl, ante, cons)
`define TTA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/tta_pkg.sv =====
// Shared types, constants and helpers of the triangle tangent accumulator.
`default_nettype none
package tta_pkg;
	localparam int COORD_BITS = 16;
	localparam int FIELD_W = 16;
	localparam int IDX_W = 10;
	localparam int DELTA_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DELTA_W;
	localparam int VEC_W = PROD_W + 1;
	localparam int ACC_W = 20;
	localparam int ENTRY_W = 6 * ACC_W;
	localparam int NORM_W = 16;
	localparam int THR_W = 20;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1678);
	localparam int FRAC = 14;
	localparam int UNIT = 1 << FRAC;
	localparam int TOP_BIT = 29;
	localparam int VERTEX_COUNT_DEF = 1024;
	localparam int QUEUE_DEPTH = 2;
	localparam int MUL_OPS = 14;

	localparam logic CMD_CORNER = 1'b0;
	localparam logic CMD_READOUT = 1'b1;
	localparam logic KIND_TRIANGLE = 1'b0;
	localparam logic KIND_READOUT = 1'b1;

	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic signed [VEC_W-1:0] vec_t;
	typedef logic signed [NORM_W-1:0] norm_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic cmd;
		logic [IDX_W-1:0] vertex_index;
		logic signed [FIELD_W-1:0] pos_x;
		logic signed [FIELD_W-1:0] pos_y;
		logic signed [FIELD_W-1:0] pos_z;
		logic signed [FIELD_W-1:0] tex_u;
		logic signed [FIELD_W-1:0] tex_v;
	} item_t;

	typedef struct packed {
		logic kind;
		logic [IDX_W-1:0] vertex_out;
		logic signed [NORM_W-1:0] tangent_x;
		logic signed [NORM_W-1:0] tangent_y;
		logic signed [NORM_W-1:0] tangent_z;
		logic signed [NORM_W-1:0] bitangent_x;
		logic signed [NORM_W-1:0] bitangent_y;
		logic signed [NORM_W-1:0] bitangent_z;
		logic degenerate;
	} result_t;

	typedef logic [THR_W-1:0] thr_t;

	// One unit of work for the back end: a readout or an assembled triangle.
	typedef struct packed {
		logic is_read;
		logic [2:0][IDX_W-1:0] idx;
		delta_t [2:0] p;
		delta_t [2:0] q;
		delta_t s1;
		delta_t t1;
		delta_t s2;
		delta_t t2;
	} job_t;

	typedef enum logic [3:0] {
		B_CLEAR, B_IDLE, B_MUL, B_SIGN, B_RD_ISSUE, B_RD_DATA,
		B_NSTART, B_NORM, B_ACC_RD, B_ACC_WR, B_EMIT
	} back_state_t;

	typedef enum logic [2:0] {
		N_IDLE, N_ZERO, N_SHIFT, N_SQ, N_SQRT, N_DIVLD, N_DIV
	} norm_state_t;

	function automatic acc_t sat_add(acc_t a, norm_t b);
		logic signed [ACC_W:0] s;
		s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
		if (s > $signed({2'b00, {(ACC_W-1){1'b1}}}))
			return {1'b0, {(ACC_W-1){1'b1}}};
		else if (s < $signed({2'b11, {(ACC_W-1){1'b0}}}))
			return {1'b1, {(ACC_W-1){1'b0}}};
		else
			return ACC_W'(s);
	endfunction
endpackage
`default_nettype wire

// ===== design/tta_chan_if.sv =====
// Valid/ready channel carrying one payload.
`default_nettype none
interface tta_chan_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/triangle_tangent_accumulator.sv =====
// Top level of the triangle tangent accumulator.
// Corners enter one per cycle unless the memory clear runs or the queue is full; every
// third corner and every readout becomes a job in a two-entry queue that a sequential
// back end works off one at a time. A job's time is dominated by the normalizer
// (one-bit scaling, bit-pair square root and three divisions), plus the products on
// the shared 17x17 multiplier and the accumulator read-modify-writes on the memory
// with one read and one write port; all-zero vectors skip the normalizer's scaling,
// root and division and finish far sooner. After reset the accumulator memory is
// cleared entry by entry, during which no request is taken; threshold writes are taken
// at any time with ready held high.
`default_nettype none
`include "triangle_tangent_accumulator_assert.svh"
module triangle_tangent_accumulator import tta_pkg::*; #(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tta_chan_if.sink   item_ch,
	tta_chan_if.source result_ch,
	tta_chan_if.sink   cfg_ch
);
	thr_t threshold_q;
	logic clearing, q_push, q_full, q_pop, q_empty;
	job_t push_job, pop_job;
	item_t item;
	result_t result;

	assign cfg_ch.ready = 1'b1;
	assign item = item_ch.data;
	assign result_ch.data = result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			threshold_q <= THR_RESET;
		else if (cfg_ch.valid)
			threshold_q <= cfg_ch.data;
	end

	tta_front u_front (
		.clk(clk), .arst_n(arst_n), .hold(clearing),
		.item_valid(item_ch.valid), .item_ready(item_ch.ready), .item(item),
		.push(q_push), .push_job(push_job), .q_full(q_full)
	);

	tta_queue #(.T(job_t), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(q_push), .din(push_job), .full(q_full),
		.pop(q_pop), .dout(pop_job), .empty(q_empty)
	);

	tta_back #(.VERTEX_COUNT(VERTEX_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n), .threshold(threshold_q), .clearing(clearing),
		.q_empty(q_empty), .pop(q_pop), .job(pop_job),
		.out_valid(result_ch.valid), .out_ready(result_ch.ready), .out_data(result)
	);

	`TTA_ASSERT_IMP(a_hold_while_clearing, clearing, !item_ch.ready)
	`TTA_ASSERT_IMP(a_readout_not_degen, result_ch.valid && result.kind == KIND_READOUT, !result.degenerate)
	`TTA_ASSERT_IMP(a_triangle_no_vertex, result_ch.valid && result.kind == KIND_TRIANGLE, result.vertex_out == '0)
	`TTA_ASSERT_NEXT(a_threshold_write, cfg_ch.valid, threshold_q == $past(cfg_ch.data))
endmodule
`default_nettype wire

// ===== design/tta_queue.sv =====
// Short FIFO between the front end and the back end.
`default_nettype none
module tta_queue #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     din,
	output logic full,
	input  logic pop,
	output T     dout,
	output logic empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	T slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign dout = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (pop)
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== design/tta_front.sv =====
// Front end: takes requests, assembles triangles and queues jobs.
`default_nettype none
module tta_front import tta_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  hold,
	input  logic  item_valid,
	output logic  item_ready,
	input  item_t item,
	output logic  push,
	output job_t  push_job,
	input  logic  q_full
);
	localparam logic [1:0] LAST_SLOT = 2'd2;

	logic signed [COORD_BITS-1:0] cpos_q [2][3];
	logic signed [COORD_BITS-1:0] cuv_q [2][2];
	logic [IDX_W-1:0] cidx_q [2];
	logic [1:0] cnt_q;

	logic signed [COORD_BITS-1:0] pos [3];
	logic signed [COORD_BITS-1:0] uv [2];
	logic accept, is_corner;

	assign pos[0] = item.pos_x[COORD_BITS-1:0];
	assign pos[1] = item.pos_y[COORD_BITS-1:0];
	assign pos[2] = item.pos_z[COORD_BITS-1:0];
	assign uv[0] = item.tex_u[COORD_BITS-1:0];
	assign uv[1] = item.tex_v[COORD_BITS-1:0];

	assign item_ready = !hold && !q_full;
	assign accept = item_valid && item_ready;
	assign is_corner = (item.cmd == CMD_CORNER);
	assign push = accept && (!is_corner || cnt_q == LAST_SLOT);

	always_comb begin
		push_job.is_read = !is_corner;
		push_job.idx[0] = cidx_q[0];
		push_job.idx[1] = cidx_q[1];
		push_job.idx[2] = item.vertex_index;
		for (int i = 0; i < 3; i++) begin
			push_job.p[i] = DELTA_W'(cpos_q[1][i]) - DELTA_W'(cpos_q[0][i]);
			push_job.q[i] = DELTA_W'(pos[i]) - DELTA_W'(cpos_q[0][i]);
		end
		push_job.s1 = DELTA_W'(cuv_q[1][0]) - DELTA_W'(cuv_q[0][0]);
		push_job.t1 = DELTA_W'(cuv_q[1][1]) - DELTA_W'(cuv_q[0][1]);
		push_job.s2 = DELTA_W'(uv[0]) - DELTA_W'(cuv_q[0][0]);
		push_job.t2 = DELTA_W'(uv[1]) - DELTA_W'(cuv_q[0][1]);
	end

	always_ff @(posedge clk) begin
		if (accept && is_corner && cnt_q != LAST_SLOT) begin
			for (int i = 0; i < 3; i++)
				cpos_q[cnt_q[0]][i] <= pos[i];
			cuv_q[cnt_q[0]][0] <= uv[0];
			cuv_q[cnt_q[0]][1] <= uv[1];
			cidx_q[cnt_q[0]] <= item.vertex_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept && is_corner) begin
			cnt_q <= (cnt_q == LAST_SLOT) ? 2'd0 : cnt_q + 2'd1;
		end
	end
endmodule
`default_nettype wire

// ===== design/tta_norm.sv =====
// Iterative vector normalizer: scale, sum of squares, root, then division.
`default_nettype none
module tta_norm import tta_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  vec_t [2:0]     vec,
	output logic           busy,
	output norm_t [2:0]    res
);
	localparam int MAG_W = VEC_W;
	localparam int SQ_W = 2 * (TOP_BIT + 1);
	localparam int SUM_W = SQ_W + 2;
	localparam int SR_W = SUM_W + 2;
	localparam int R_W = SUM_W / 2 + 1;
	localparam int Q_W = FRAC + 1;
	localparam int NUM_W = TOP_BIT + 1 + FRAC + 1;
	localparam int SQRT_STEPS = SR_W / 2;

	norm_state_t state_q, state_d;
	logic [MAG_W-1:0] mag_q [3];
	logic neg_q [3];
	logic [4:0] cnt_q;
	logic [1:0] k_q;
	logic [SQ_W-1:0] sq_q;
	logic [SUM_W-1:0] x_q;
	logic [SR_W-1:0] root_q, bit_q;
	logic [R_W:0] rem_q;
	logic [Q_W-1:0] numlo_q, quo_q;
	norm_t [2:0] res_q;

	logic [MAG_W-1:0] m, msel;
	logic [1:0] sel;
	logic [SR_W-1:0] xx, trial;
	logic [R_W-1:0] r;
	logic [NUM_W-1:0] num;
	logic [R_W:0] rem2;
	logic [Q_W-1:0] quo_next;
	logic fits, vec_zero;

	assign busy = (state_q != N_IDLE);
	assign res = res_q;

	always_comb begin
		m = mag_q[0];
		if (mag_q[1] > m) m = mag_q[1];
		if (mag_q[2] > m) m = mag_q[2];
		sel = (state_q == N_SQ) ? cnt_q[1:0] : k_q;
		case (sel)
			2'd0: msel = mag_q[0];
			2'd1: msel = mag_q[1];
			default: msel = mag_q[2];
		endcase
		vec_zero = (vec[0] == '0) && (vec[1] == '0) && (vec[2] == '0);
		xx = SR_W'(x_q);
		trial = root_q + bit_q;
		r = R_W'(root_q);
		num = (NUM_W'(msel[TOP_BIT:0]) << FRAC) + NUM_W'(r >> 1);
		rem2 = {rem_q[R_W-1:0], numlo_q[Q_W-1]};
		fits = (rem2 >= {1'b0, r});
		quo_next = {quo_q[Q_W-2:0], fits};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			N_IDLE: if (start) state_d = vec_zero ? N_ZERO : N_SHIFT;
			N_ZERO: state_d = N_IDLE;
			N_SHIFT: if (m[MAG_W-1:TOP_BIT+1] == '0 && m[TOP_BIT]) state_d = N_SQ;
			N_SQ: if (cnt_q == 5'd3) state_d = N_SQRT;
			N_SQRT: if (cnt_q == 5'(SQRT_STEPS - 1)) state_d = N_DIVLD;
			N_DIVLD: state_d = N_DIV;
			N_DIV: if (cnt_q == 5'(Q_W - 1)) state_d = (k_q == 2'd2) ? N_IDLE : N_DIVLD;
			default: state_d = N_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= N_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					for (int i = 0; i < 3; i++) begin
						neg_q[i] <= vec[i][VEC_W-1];
						mag_q[i] <= vec[i][VEC_W-1] ? MAG_W'(-vec[i]) : MAG_W'(vec[i]);
					end
				end
			end
			N_ZERO: res_q <= '0;
			N_SHIFT: begin
				// one bit per cycle; truncating right shifts compose exactly
				if (m[MAG_W-1:TOP_BIT+1] != '0) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
				end else if (!m[TOP_BIT]) begin
					for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
				end else begin
					cnt_q <= '0;
					x_q <= '0;
				end
			end
			N_SQ: begin
				if (cnt_q != 5'd3)
					sq_q <= msel[TOP_BIT:0] * msel[TOP_BIT:0];
				if (cnt_q != 5'd0)
					x_q <= x_q + SUM_W'(sq_q);
				if (cnt_q == 5'd3) begin
					cnt_q <= '0;
					root_q <= '0;
					bit_q <= SR_W'(1) << (SR_W - 2);
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
			N_SQRT: begin
				if (xx >= trial) begin
					x_q <= SUM_W'(xx - trial);
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= (cnt_q == 5'(SQRT_STEPS - 1)) ? 5'd0 : cnt_q + 5'd1;
				k_q <= '0;
			end
			N_DIVLD: begin
				rem_q <= (R_W+1)'(num >> Q_W);
				numlo_q <= num[Q_W-1:0];
				quo_q <= '0;
				cnt_q <= '0;
			end
			N_DIV: begin
				rem_q <= fits ? rem2 - {1'b0, r} : rem2;
				numlo_q <= numlo_q << 1;
				quo_q <= quo_next;
				if (cnt_q == 5'(Q_W - 1)) begin
					if (neg_q[k_q])
						res_q[k_q] <= (quo_next > Q_W'(UNIT)) ? -norm_t'(UNIT) :
							-norm_t'(quo_next);
					else
						res_q[k_q] <= (quo_next > Q_W'(UNIT)) ? norm_t'(UNIT) :
							norm_t'(quo_next);
					k_q <= k_q + 2'd1;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== design/tta_back.sv =====
// Back end: products, sign fix, normalization, accumulator update and result register.
`default_nettype none
module tta_back import tta_pkg::*; #(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  thr_t    threshold,
	output logic    clearing,
	input  logic    q_empty,
	output logic    pop,
	input  job_t    job,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);
	localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

	back_state_t state_q, state_d;
	job_t job_q;
	logic [3:0] mcnt_q;
	logic [1:0] k_q;
	logic [AW-1:0] clr_q;
	logic signed [PROD_W-1:0] prod_q;
	vec_t det_q;
	vec_t [2:0] tv_q, bv_q;
	logic degen_q;
	logic out_valid_q;
	result_t out_q;

	logic [ENTRY_W-1:0] acc_mem [VERTEX_COUNT];
	logic [ENTRY_W-1:0] mem_rd_q, mem_wd;
	logic [AW-1:0] mem_ra, mem_wa;
	logic mem_we;

	logic norm_start, t_busy, b_busy, out_load;
	norm_t [2:0] tn, bn;
	delta_t mul_a, mul_b;
	logic signed [PROD_W-1:0] prod_d;
	logic [3:0] jm, ja;
	logic [IDX_W-1:0] acc_idx;
	vec_t prod_ext;
	logic [VEC_W-1:0] adet;
	logic degen, flip;

	function automatic logic in_range(logic [IDX_W-1:0] i);
		return 32'(i) < VERTEX_COUNT;
	endfunction

	function automatic delta_t pick(delta_t [2:0] v, logic [1:0] c);
		case (c)
			2'd0: return v[0];
			2'd1: return v[1];
			default: return v[2];
		endcase
	endfunction

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	tta_norm u_norm_t (
		.clk(clk), .arst_n(arst_n), .start(norm_start), .vec(tv_q),
		.busy(t_busy), .res(tn)
	);
	tta_norm u_norm_b (
		.clk(clk), .arst_n(arst_n), .start(norm_start), .vec(bv_q),
		.busy(b_busy), .res(bn)
	);

	// Shared multiplier schedule: det, then per axis t2*P, t1*Q, s1*Q, s2*P.
	always_comb begin
		jm = mcnt_q - 4'd2;
		mul_a = '0;
		mul_b = '0;
		if (mcnt_q == 4'd0) begin
			mul_a = job_q.s1;
			mul_b = job_q.t2;
		end else if (mcnt_q == 4'd1) begin
			mul_a = job_q.s2;
			mul_b = job_q.t1;
		end else if (mcnt_q < 4'(MUL_OPS)) begin
			case (jm[1:0])
				2'd0: begin mul_a = job_q.t2; mul_b = pick(job_q.p, jm[3:2]); end
				2'd1: begin mul_a = job_q.t1; mul_b = pick(job_q.q, jm[3:2]); end
				2'd2: begin mul_a = job_q.s1; mul_b = pick(job_q.q, jm[3:2]); end
				default: begin mul_a = job_q.s2; mul_b = pick(job_q.p, jm[3:2]); end
			endcase
		end
		prod_d = mul_a * mul_b;
		ja = mcnt_q - 4'd3;
		prod_ext = VEC_W'(prod_q);
		adet = det_q[VEC_W-1] ? VEC_W'(-det_q) : VEC_W'(det_q);
		degen = adet <= VEC_W'(threshold);
		flip = !degen && det_q[VEC_W-1];
		acc_idx = job_q.idx[k_q];
		for (int i = 0; i < 3; i++) begin
			mem_wd[ACC_W*i +: ACC_W] = sat_add(acc_t'(mem_rd_q[ACC_W*i +: ACC_W]), tn[i]);
			mem_wd[3*ACC_W + ACC_W*i +: ACC_W] =
				sat_add(acc_t'(mem_rd_q[3*ACC_W + ACC_W*i +: ACC_W]), bn[i]);
		end
	end

	always_comb begin
		state_d = state_q;
		clearing = 1'b0;
		pop = 1'b0;
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_ra = AW'(acc_idx);
		norm_start = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			B_CLEAR: begin
				clearing = 1'b1;
				mem_we = 1'b1;
				if (clr_q == AW'(VERTEX_COUNT - 1)) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (!q_empty) begin
					pop = 1'b1;
					state_d = job.is_read ? B_RD_ISSUE : B_MUL;
				end
			end
			B_MUL: if (mcnt_q == 4'(MUL_OPS)) state_d = B_SIGN;
			B_SIGN: state_d = B_NSTART;
			B_RD_ISSUE: begin
				// read old sums and clear the entry in the same cycle
				mem_ra = AW'(job_q.idx[2]);
				mem_wa = AW'(job_q.idx[2]);
				mem_we = in_range(job_q.idx[2]);
				state_d = B_RD_DATA;
			end
			B_RD_DATA: state_d = B_NSTART;
			B_NSTART: begin
				norm_start = 1'b1;
				state_d = B_NORM;
			end
			B_NORM: if (!t_busy && !b_busy) state_d = job_q.is_read ? B_EMIT : B_ACC_RD;
			B_ACC_RD: state_d = B_ACC_WR;
			B_ACC_WR: begin
				mem_wa = AW'(acc_idx);
				mem_we = in_range(acc_idx);
				state_d = (k_q == 2'd2) ? B_EMIT : B_ACC_RD;
			end
			B_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= B_CLEAR;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			acc_mem[mem_wa] <= (state_q == B_ACC_WR) ? mem_wd : '0;
		mem_rd_q <= acc_mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == B_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
			mcnt_q <= '0;
			k_q <= '0;
			degen_q <= 1'b0;
		end
		if (state_q == B_MUL) begin
			prod_q <= prod_d;
			mcnt_q <= mcnt_q + 4'd1;
			if (mcnt_q == 4'd1)
				det_q <= prod_ext;
			else if (mcnt_q == 4'd2)
				det_q <= det_q - prod_ext;
			else if (mcnt_q != 4'd0) begin
				if (ja[1]) begin
					if (ja[0]) bv_q[ja[3:2]] <= bv_q[ja[3:2]] - prod_ext;
					else bv_q[ja[3:2]] <= prod_ext;
				end else begin
					if (ja[0]) tv_q[ja[3:2]] <= tv_q[ja[3:2]] - prod_ext;
					else tv_q[ja[3:2]] <= prod_ext;
				end
			end
		end
		if (state_q == B_SIGN) begin
			degen_q <= degen;
			if (flip) begin
				for (int i = 0; i < 3; i++) begin
					tv_q[i] <= -tv_q[i];
					bv_q[i] <= -bv_q[i];
				end
			end
		end
		if (state_q == B_RD_DATA) begin
			for (int i = 0; i < 3; i++) begin
				tv_q[i] <= in_range(job_q.idx[2]) ?
					VEC_W'(acc_t'(mem_rd_q[ACC_W*i +: ACC_W])) : '0;
				bv_q[i] <= in_range(job_q.idx[2]) ?
					VEC_W'(acc_t'(mem_rd_q[3*ACC_W + ACC_W*i +: ACC_W])) : '0;
			end
		end
		if (state_q == B_ACC_WR)
			k_q <= k_q + 2'd1;
		if (out_load) begin
			out_q.kind <= job_q.is_read ? KIND_READOUT : KIND_TRIANGLE;
			out_q.vertex_out <= job_q.is_read ? job_q.idx[2] : '0;
			out_q.tangent_x <= tn[0];
			out_q.tangent_y <= tn[1];
			out_q.tangent_z <= tn[2];
			out_q.bitangent_x <= bn[0];
			out_q.bitangent_y <= bn[1];
			out_q.bitangent_z <= bn[2];
			out_q.degenerate <= job_q.is_read ? 1'b0 : degen_q;
		end
	end
endmodule
`default_nettype wire
